>>> rtl/cbre_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the convolution, bias and ReLU engine.
// Used by the top level and by its port checker; depends on nothing else.
package cbre_pkg;

    // Operation codes carried in the request opcode field.
    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] OP_LOAD_BIAS   = 2'd1;
    localparam logic [1:0] OP_LOAD_PIXEL  = 2'd2;
    localparam logic [1:0] OP_COMPUTE     = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IN_CHANNELS  = 2'd0;
    localparam logic [1:0] CFG_IN_SIZE      = 2'd1;
    localparam logic [1:0] CFG_OUT_CHANNELS = 2'd2;

    localparam int CFG_DATA_W = 8;

    // Reset values of the configuration registers.
    localparam logic [2:0] RST_IN_CHANNELS  = 3'd4;
    localparam logic [5:0] RST_IN_SIZE      = 6'd12;
    localparam logic [3:0] RST_OUT_CHANNELS = 4'd8;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         out_chan;
        logic [1:0]         in_chan;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [31:0] value;
    } cbre_in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               index_error;
    } cbre_out_t;

endpackage

>>> rtl/conv2d_bias_relu_engine.sv
`timescale 1ns / 1ps
// Top level of the 2-D convolution engine with bias and ReLU in Q16.16.
// Holds the weight, bias and pixel stores and one shared multiply-accumulate; uses cbre_pkg.

// A load request (weight, bias or pixel) gives no result. A compute request runs one
// multiply-accumulate per kernel tap through a single shared 32 x 32 multiplier, reading
// one weight and one pixel per cycle from their stores. A compute request with
// out-of-range indices, or with in_channels at zero, skips the taps and goes from the
// idle state straight to the output state. The input stays not ready while a compute
// request is in progress or while its result waits for the output register to free.
// The stores power up undefined and need no clearing pass; only entries that have been
// loaded may be used by a compute request.
module conv2d_bias_relu_engine
    import cbre_pkg::*;
#(
    parameter int MAX_IN_CH   = 4,
    parameter int MAX_OUT_CH  = 8,
    parameter int MAX_IN_SIZE = 32,
    parameter int KERNEL_SIZE = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  cbre_in_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output cbre_out_t             m_data,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TAPS     = KERNEL_SIZE * KERNEL_SIZE;
    localparam int W_DEPTH  = MAX_OUT_CH * MAX_IN_CH * TAPS;
    localparam int P_DEPTH  = MAX_IN_CH * MAX_IN_SIZE * MAX_IN_SIZE;
    localparam int WA_W     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int PA_W     = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int OC_W     = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int KW       = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
    localparam int KCW      = $clog2(MAX_IN_CH + 1);
    // Pixel address steps at the end of a kernel row and at the end of a channel.
    localparam int PIX_ROW_STEP = MAX_IN_SIZE - KERNEL_SIZE + 1;
    localparam int PIX_CH_STEP  = MAX_IN_SIZE * MAX_IN_SIZE
                                  - (KERNEL_SIZE - 1) * MAX_IN_SIZE - (KERNEL_SIZE - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    // Stores
    logic [31:0] weight_mem [W_DEPTH];
    logic [31:0] bias_mem   [MAX_OUT_CH];
    logic [31:0] pixel_mem  [P_DEPTH];

    // Control and datapath registers
    logic [1:0]         state_reg, state_next;
    logic [2:0]         in_ch_reg, in_ch_next;
    logic [5:0]         in_size_reg, in_size_next;
    logic [3:0]         out_ch_reg, out_ch_next;
    logic               err_reg, err_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    logic [WA_W-1:0]    waddr_reg, waddr_next;
    logic [PA_W-1:0]    paddr_reg, paddr_next;
    logic [KW-1:0]      tj_reg, tj_next;
    logic [KW-1:0]      ti_reg, ti_next;
    logic [KCW-1:0]     tk_reg, tk_next;
    logic               m_valid_reg, m_valid_next;
    cbre_out_t          m_data_reg, m_data_next;

    logic signed [31:0] w_rd_reg;
    logic signed [31:0] p_rd_reg;
    logic signed [31:0] bias_rd_reg;

    // Effective configuration
    logic [7:0] nic_eff, sz_eff, noc_eff, side;

    // Request decode
    logic        s_accept;
    logic        cfg_accept;
    logic        load_w, load_b, load_p, do_compute;
    logic        bad_index;
    logic [31:0] w_load_lin, p_load_lin, w_base_lin, p_start_lin, bias_lin;
    logic        last_j, last_i, last_k;
    logic signed [32:0] total;
    logic signed [31:0] relu_val;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign s_accept   = s_valid && s_ready;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign nic_eff = ({5'd0, in_ch_reg} > 8'(MAX_IN_CH)) ? 8'(MAX_IN_CH) : {5'd0, in_ch_reg};
    assign sz_eff  = ({2'd0, in_size_reg} > 8'(MAX_IN_SIZE)) ? 8'(MAX_IN_SIZE)
                                                           : {2'd0, in_size_reg};
    assign noc_eff = ({4'd0, out_ch_reg} > 8'(MAX_OUT_CH)) ? 8'(MAX_OUT_CH) : {4'd0, out_ch_reg};
    assign side    = (sz_eff >= 8'(KERNEL_SIZE)) ? sz_eff - 8'(KERNEL_SIZE) + 8'd1 : 8'd0;

    assign load_w = s_accept && (s_data.opcode == OP_LOAD_WEIGHT)
                    && (int'(s_data.out_chan) < MAX_OUT_CH)
                    && (int'(s_data.in_chan) < MAX_IN_CH)
                    && (int'(s_data.row) < KERNEL_SIZE)
                    && (int'(s_data.col) < KERNEL_SIZE);
    assign load_b = s_accept && (s_data.opcode == OP_LOAD_BIAS)
                    && (int'(s_data.out_chan) < MAX_OUT_CH);
    assign load_p = s_accept && (s_data.opcode == OP_LOAD_PIXEL)
                    && (int'(s_data.in_chan) < MAX_IN_CH)
                    && (int'(s_data.row) < MAX_IN_SIZE)
                    && (int'(s_data.col) < MAX_IN_SIZE);
    assign do_compute = s_accept && (s_data.opcode == OP_COMPUTE);

    assign bad_index = ({5'd0, s_data.out_chan} >= noc_eff)
                       || ({3'd0, s_data.row} >= side)
                       || ({3'd0, s_data.col} >= side);

    // Linear addresses; all multiplications here are by elaboration-time constants.
    assign w_load_lin  = (32'(s_data.out_chan) * 32'(MAX_IN_CH) + 32'(s_data.in_chan))
                         * 32'(TAPS) + 32'(s_data.row) * 32'(KERNEL_SIZE) + 32'(s_data.col);
    assign p_load_lin  = (32'(s_data.in_chan) * 32'(MAX_IN_SIZE) + 32'(s_data.row))
                         * 32'(MAX_IN_SIZE) + 32'(s_data.col);
    assign w_base_lin  = 32'(s_data.out_chan) * 32'(MAX_IN_CH * TAPS);
    assign p_start_lin = 32'(s_data.row) * 32'(MAX_IN_SIZE) + 32'(s_data.col);
    assign bias_lin    = 32'(s_data.out_chan);

    assign last_j = (tj_reg == KW'(KERNEL_SIZE - 1));
    assign last_i = (ti_reg == KW'(KERNEL_SIZE - 1));
    assign last_k = ((8'(tk_reg) + 8'd1) == nic_eff);

    // The ReLU tests the exact 33-bit bias sum before it is wrapped.
    assign total    = 33'(acc_reg) + 33'(bias_rd_reg);
    assign relu_val = total[32] ? 32'sd0 : total[31:0];

    // Stores: one write port and one registered read port each.
    always_ff @(posedge aclk) begin
        if (load_w) begin
            weight_mem[w_load_lin[WA_W-1:0]] <= s_data.value;
        end
        if (load_p) begin
            pixel_mem[p_load_lin[PA_W-1:0]] <= s_data.value;
        end
        if (load_b) begin
            bias_mem[bias_lin[OC_W-1:0]] <= s_data.value;
        end
        if (do_compute) begin
            bias_rd_reg <= bias_mem[bias_lin[OC_W-1:0]];
        end
        w_rd_reg <= weight_mem[waddr_reg];
        p_rd_reg <= pixel_mem[paddr_reg];
    end

    always_comb begin
        state_next   = state_reg;
        in_ch_next   = in_ch_reg;
        in_size_next = in_size_reg;
        out_ch_next  = out_ch_reg;
        err_next     = err_reg;
        acc_next     = acc_reg;
        waddr_next   = waddr_reg;
        paddr_next   = paddr_reg;
        tj_next      = tj_reg;
        ti_next      = ti_reg;
        tk_next      = tk_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        // Read, multiply and accumulate stages behind the tap sequencer.
        v1_next   = (state_reg == ST_RUN);
        v2_next   = v1_reg;
        prod_next = v1_reg ? 64'(w_rd_reg) * 64'(p_rd_reg) : prod_reg;
        if (v2_reg) begin
            acc_next = acc_reg + prod_reg[47:16];
        end

        if (cfg_accept) begin
            case (cfg_index)
                CFG_IN_CHANNELS:  in_ch_next   = cfg_data[2:0];
                CFG_IN_SIZE:      in_size_next = cfg_data[5:0];
                CFG_OUT_CHANNELS: out_ch_next  = cfg_data[3:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (do_compute) begin
                    err_next   = bad_index;
                    acc_next   = 32'sd0;
                    waddr_next = w_base_lin[WA_W-1:0];
                    paddr_next = p_start_lin[PA_W-1:0];
                    tj_next    = '0;
                    ti_next    = '0;
                    tk_next    = '0;
                    state_next = (bad_index || (nic_eff == 8'd0)) ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN: begin
                // Weights of one output channel are contiguous over channels and taps.
                waddr_next = waddr_reg + WA_W'(1);
                if (!last_j) begin
                    tj_next    = tj_reg + KW'(1);
                    paddr_next = paddr_reg + PA_W'(1);
                end else if (!last_i) begin
                    tj_next    = '0;
                    ti_next    = ti_reg + KW'(1);
                    paddr_next = paddr_reg + PA_W'(PIX_ROW_STEP);
                end else if (!last_k) begin
                    tj_next    = '0;
                    ti_next    = '0;
                    tk_next    = tk_reg + KCW'(1);
                    paddr_next = paddr_reg + PA_W'(PIX_CH_STEP);
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.index_error  = err_reg;
                    m_data_next.result       = err_reg ? 32'sd0 : relu_val;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_ch_reg   <= RST_IN_CHANNELS;
            in_size_reg <= RST_IN_SIZE;
            out_ch_reg  <= RST_OUT_CHANNELS;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_ch_reg   <= in_ch_next;
            in_size_reg <= in_size_next;
            out_ch_reg  <= out_ch_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg    <= err_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        waddr_reg  <= waddr_next;
        paddr_reg  <= paddr_next;
        tj_reg     <= tj_next;
        ti_reg     <= ti_next;
        tk_reg     <= tk_next;
        m_data_reg <= m_data_next;
    end

endmodule

>>> rtl/cbre_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the convolution engine, bound to the top level.
// Depends on cbre_pkg for the request and result types and the opcodes.
module cbre_checker
    import cbre_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input cbre_in_t              s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input cbre_out_t             m_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [1:0]            cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // A result that has not been taken stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // An index error always carries a zero result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.index_error |-> m_data.result == 32'sd0)
        else $error("index error with a non-zero result");

    // A load request never produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode != OP_COMPUTE) && !m_valid |=> !m_valid)
        else $error("result appeared after a load request");

    // A compute request occupies the engine for at least the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_COMPUTE) |=> !s_ready)
        else $error("engine ready straight after a compute request");

endmodule

bind conv2d_bias_relu_engine cbre_checker u_cbre_checker (.*);
